// ===== hw/rtl/ppe_pkg.sv =====
// Shared types and constants for the piecewise profile evaluator.
`timescale 1ns / 1ps
`default_nettype none

package ppe_pkg;

	// Field widths of one beat.
	localparam int VAL_W   = 24;
	localparam int TIME_W  = 23;  // nonnegative query time, sign bit dropped
	localparam int ACC_W   = 25;  // accumulated time plus one duration
	localparam int MUL_W   = 25;  // shared multiplier operand
	localparam int PROD_W  = 2 * MUL_W;
	localparam int SS_W    = 2 * TIME_W;
	localparam int PART_W  = 27;  // low partial product of a*s*s after the shift
	localparam int HALF_W  = 38;  // floor(a*s*s / 2^33)

	localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_APPEND  = 2'd1,
		OP_SET_END = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	localparam logic [1:0] WHERE_BEFORE = 2'd0;
	localparam logic [1:0] WHERE_INSIDE = 2'd1;
	localparam logic [1:0] WHERE_PAST   = 2'd2;

	typedef struct packed {
		logic        [VAL_W-1:0] duration;
		logic signed [VAL_W-1:0] accel;
		logic signed [VAL_W-1:0] distance;
		logic signed [VAL_W-1:0] end_velocity;
	} seg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ppe_seg_store.sv =====
// Segment table: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ppe_seg_store #(
	parameter int MAX_SEGMENTS = 16,
	parameter int IDX_W = 4
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire ppe_pkg::seg_t    wr_data,
	input  wire logic [IDX_W-1:0] rd_addr,
	output ppe_pkg::seg_t         rd_data_q
);
	import ppe_pkg::*;

	seg_t mem [MAX_SEGMENTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ppe_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module ppe_mul (
	input  wire logic                              clk,
	input  wire logic signed [ppe_pkg::MUL_W-1:0]  op_a,
	input  wire logic signed [ppe_pkg::MUL_W-1:0]  op_b,
	output logic signed      [ppe_pkg::PROD_W-1:0] prod_q
);
	import ppe_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/piecewise_profile_evaluator.sv =====
// Top level: command decode, segment walk sequencer and result assembly.
// Clear, append and set-end beats leave the sequencer idle; the block is ready the next cycle.
// A query resolves before the walk when its time is negative, the table is empty or the
// time reaches the end time; else it walks one table entry per cycle (1..MAX_SEGMENTS),
// and if t lies in a segment uses the shared multiplier: a*s for velocity, or s*s, a times
// each half of s*s and v*s for position; its result goes valid when the next beat can be taken.
// arst_n clears the segment count, end values, sequencer, pending result and output valid; the table is kept.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_profile_evaluator #(
	parameter int MAX_SEGMENTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [23:0] seg_duration,
	input  wire logic signed [23:0] seg_accel,
	input  wire logic signed [23:0] seg_distance,
	input  wire logic signed [23:0] seg_end_velocity,
	input  wire logic [23:0] end_time,
	input  wire logic signed [23:0] end_position,
	input  wire logic signed [23:0] query_time,
	input  wire logic        want_velocity,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [23:0] value,
	output logic [1:0]       where_in_profile
);
	import ppe_pkg::*;

	localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	// Distance sum over up to MAX_SEGMENTS entries
	localparam int POS_W = VAL_W + 1 + $clog2(MAX_SEGMENTS);
	localparam int SUM_W = ((POS_W > HALF_W) ? POS_W : HALF_W) + 2;
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(VAL_MAX);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(VAL_MIN);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_MUL0,
		S_V_SUM,
		S_P_LO,
		S_P_HI,
		S_P_VS,
		S_P_SUM
	} state_t;

	// ---------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------
	state_t                    state_q;
	logic                      res_pend_q;   // result waiting for the output slot
	logic [CNT_W-1:0]          cnt_q;
	logic [VAL_W-1:0]          end_time_q;
	logic signed [VAL_W-1:0]   end_pos_q;
	logic [IDX_W-1:0]          idx_q;
	logic [TIME_W-1:0]         t_q;
	logic                      want_v_q;
	logic [TIME_W-1:0]         acc_time_q;
	logic signed [POS_W-1:0]   acc_pos_q;
	logic signed [VAL_W-1:0]   vel_q;
	logic signed [VAL_W-1:0]   a_q;
	logic [TIME_W-1:0]         s_q;
	logic [TIME_W-1:0]         ss_hi_q;
	logic signed [PART_W-1:0]  part_q;
	logic signed [HALF_W-1:0]  half_q;
	logic signed [VAL_W-1:0]   res_value_q;
	logic [1:0]                res_where_q;
	logic                      out_valid_q;
	logic signed [VAL_W-1:0]   value_q;
	logic [1:0]                where_q;

	// ---------------------------------------------------------------
	// Submodules
	// ---------------------------------------------------------------
	logic                      in_fire;
	logic                      wr_en;
	seg_t                      wr_data;
	logic [IDX_W-1:0]          rd_addr;
	seg_t                      rd_data_q;
	logic signed [MUL_W-1:0]   op_a;
	logic signed [MUL_W-1:0]   op_b;
	logic signed [PROD_W-1:0]  prod_q;

	assign in_stall = (state_q != S_IDLE) || res_pend_q;
	assign in_fire  = in_valid && !in_stall;

	// Append a beat's segment only while the table has room.
	assign wr_en = in_fire && (opcode == OP_APPEND) && (cnt_q < CNT_W'(MAX_SEGMENTS));
	assign wr_data = '{duration: seg_duration, accel: seg_accel,
		distance: seg_distance, end_velocity: seg_end_velocity};

	// Prefetch entry 0 while idle; during the walk fetch the entry after the one
	// under test so a segment is checked every cycle.
	assign rd_addr = (state_q == S_WALK) ? idx_q + IDX_W'(1) : '0;

	ppe_seg_store #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.IDX_W        (IDX_W)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (cnt_q[IDX_W-1:0]),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data_q)
	);

	// Operand select for the shared multiplier, one product per state.
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_MUL0: begin
				// a*s for velocity, s*s for position
				op_a = want_v_q ? MUL_W'(a_q) : $signed({2'b00, s_q});
				op_b = $signed({2'b00, s_q});
			end
			S_P_LO: begin
				op_a = MUL_W'(a_q);
				op_b = $signed({2'b00, prod_q[TIME_W-1:0]});
			end
			S_P_HI: begin
				op_a = MUL_W'(a_q);
				op_b = $signed({2'b00, ss_hi_q});
			end
			S_P_VS: begin
				op_a = MUL_W'(vel_q);
				op_b = $signed({2'b00, s_q});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	ppe_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	// ---------------------------------------------------------------
	// Walk compare: time t belongs to the segment whose end it does not pass.
	// ---------------------------------------------------------------
	logic [ACC_W-1:0] seg_end;
	logic             seg_hit;
	logic             walk_last;

	assign seg_end   = ACC_W'(acc_time_q) + ACC_W'(rd_data_q.duration);
	assign seg_hit   = ACC_W'(t_q) <= seg_end;
	assign walk_last = (CNT_W'(idx_q) == cnt_q - CNT_W'(1));

	// ---------------------------------------------------------------
	// Arithmetic on the registered product
	// ---------------------------------------------------------------
	logic signed [PROD_W-1:0] half_full;
	logic signed [SUM_W-1:0]  vel_sum;
	logic signed [SUM_W-1:0]  pos_sum;

	// floor(a*s*s/2^33) = floor((a*ss_hi + floor(a*ss_lo/2^23)) / 2^10)
	assign half_full = (prod_q + PROD_W'(part_q)) >>> 10;
	assign vel_sum   = SUM_W'(vel_q) + SUM_W'(prod_q >>> 16);
	assign pos_sum   = SUM_W'(acc_pos_q) + SUM_W'(prod_q >>> 16) + SUM_W'(half_q);

	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] x);
		logic signed [VAL_W-1:0] r;
		if (x > SAT_HI) begin
			r = VAL_MAX;
		end else if (x < SAT_LO) begin
			r = VAL_MIN;
		end else begin
			r = x[VAL_W-1:0];
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Sequencer, table state and output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_pend_q  <= 1'b0;
			cnt_q       <= '0;
			end_time_q  <= '0;
			end_pos_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Refill the output slot from a pending result, else drop the beat once taken.
			if (res_pend_q && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
				value_q     <= res_value_q;
				where_q     <= res_where_q;
				res_pend_q  <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						case (opcode)
							OP_CLEAR: begin
								cnt_q <= '0;
							end
							OP_APPEND: begin
								if (wr_en) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							OP_SET_END: begin
								end_time_q <= end_time;
								end_pos_q  <= end_position;
							end
							OP_QUERY: begin
								t_q        <= query_time[TIME_W-1:0];
								want_v_q   <= want_velocity;
								idx_q      <= '0;
								acc_time_q <= '0;
								acc_pos_q  <= '0;
								vel_q      <= '0;
								if (query_time[VAL_W-1] || (cnt_q == '0)) begin
									res_value_q <= '0;
									res_where_q <= WHERE_BEFORE;
									res_pend_q  <= 1'b1;
								end else if (query_time[VAL_W-1:0] >= end_time_q) begin
									res_value_q <= want_velocity ? '0 : end_pos_q;
									res_where_q <= WHERE_PAST;
									res_pend_q  <= 1'b1;
								end else begin
									state_q <= S_WALK;
								end
							end
							default: begin
								cnt_q <= cnt_q;
							end
						endcase
					end
				end

				S_WALK: begin
					if (seg_hit) begin
						// Hold the segment's acceleration and the time into it.
						a_q     <= rd_data_q.accel;
						s_q     <= t_q - acc_time_q;
						state_q <= S_MUL0;
					end else if (walk_last) begin
						// Past every segment but before the end time: treat as past end.
						res_value_q <= want_v_q ? '0 : end_pos_q;
						res_where_q <= WHERE_PAST;
						res_pend_q  <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						acc_time_q <= seg_end[TIME_W-1:0];
						acc_pos_q  <= acc_pos_q + POS_W'(rd_data_q.distance);
						vel_q      <= rd_data_q.end_velocity;
						idx_q      <= idx_q + IDX_W'(1);
					end
				end

				S_MUL0: begin
					state_q <= want_v_q ? S_V_SUM : S_P_LO;
				end

				S_V_SUM: begin
					res_value_q <= sat_val(vel_sum);
					res_where_q <= WHERE_INSIDE;
					res_pend_q  <= 1'b1;
					state_q     <= S_IDLE;
				end

				S_P_LO: begin
					// prod_q holds s*s; keep its upper half for the next product.
					ss_hi_q <= prod_q[SS_W-1:TIME_W];
					state_q <= S_P_HI;
				end

				S_P_HI: begin
					part_q  <= PART_W'(prod_q >>> TIME_W);
					state_q <= S_P_VS;
				end

				S_P_VS: begin
					half_q  <= half_full[HALF_W-1:0];
					state_q <= S_P_SUM;
				end

				S_P_SUM: begin
					res_value_q <= sat_val(pos_sum);
					res_where_q <= WHERE_INSIDE;
					res_pend_q  <= 1'b1;
					state_q     <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign value            = value_q;
	assign where_in_profile = where_q;

endmodule

`default_nettype wire
